FILE: design/tnrxneg_pkg.sv
package tnrxneg_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] func_t;
	typedef logic [1:0] opt_state_t;
	typedef logic [2:0] parse_state_t;

	localparam byte_t IAC         = 8'd255;
	localparam byte_t CMD_WILL    = 8'd251;
	localparam byte_t CMD_WONT    = 8'd252;
	localparam byte_t CMD_DO      = 8'd253;
	localparam byte_t CMD_DONT    = 8'd254;
	localparam byte_t OPTION_SGA  = 8'd3;
	localparam byte_t OPTION_ECHO = 8'd1;
	localparam byte_t CHCRT       = 8'd13;
	localparam byte_t CHNUL       = 8'd0;
	localparam byte_t CHLFD       = 8'd10;

	localparam func_t FUNC_RX_BYTE = 2'd0;
	localparam func_t FUNC_ECHO    = 2'd1;
	localparam func_t FUNC_SGA     = 2'd2;

	localparam parse_state_t PS_NORMAL = 3'd0;
	localparam parse_state_t PS_CR     = 3'd1;
	localparam parse_state_t PS_IAC    = 3'd2;
	localparam parse_state_t PS_WILL   = 3'd3;
	localparam parse_state_t PS_WONT   = 3'd4;
	localparam parse_state_t PS_DO     = 3'd5;
	localparam parse_state_t PS_DONT   = 3'd6;

	localparam opt_state_t OS_DISABLED = 2'd0;
	localparam opt_state_t OS_ENABLED  = 2'd1;
	localparam opt_state_t OS_WAITING  = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// Result queue depth; one request makes at most two results.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic  kind;
		byte_t value;
		byte_t option;
		logic  last;
	} result_t;

endpackage

FILE: design/telnet_receive_negotiator.sv
// Receive side of one TELNET line. Each request is a byte received from the peer
// (func 0), a local set-echo request (func 1) or a local suppress-go-ahead negotiation
// (func 2). Results come out in order on the output channel: kind 0 is a data byte for
// the host, kind 1 stands for the three-byte command IAC value option to be sent to the
// peer, and last marks the final result of a request. One request is taken every clock
// cycle while ready is high; the parse and option states are updated in the cycle the
// request is accepted and its results are written straight into a four-entry result
// queue, so they can be taken from the next cycle on. A request makes zero, one or two
// results, and the output side moves one result per cycle while out_ready is high.
// Ready is low while fewer than two queue entries are free.
module telnet_receive_negotiator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tnrxneg_pkg::func_t  func,
	input  tnrxneg_pkg::byte_t  byte_in,
	input  logic                echo_on,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output tnrxneg_pkg::byte_t  value,
	output tnrxneg_pkg::byte_t  option,
	output logic                last
);
	import tnrxneg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	parse_state_t parse_q, parse_d;
	opt_state_t   echo_q, echo_d;
	opt_state_t   lsga_q, lsga_d;
	opt_state_t   rsga_q, rsga_d;

	result_t      queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic         push0, push1;
	result_t      res0, res1;
	logic         in_fire, out_fire;

	// Reply slots; the last flag is set once the count is known.
	logic         cmd0_v, cmd1_v;
	byte_t        cmd0_code, cmd0_opt, cmd1_code, cmd1_opt;
	logic         data_v;
	byte_t        data_byte;
	parse_state_t ps_eff;

	assign in_ready  = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign in_fire   = in_valid & in_ready;
	assign out_valid = (count_q != '0);
	assign out_fire  = out_valid & out_ready;

	assign kind   = queue_q[rd_ptr_q].kind;
	assign value  = queue_q[rd_ptr_q].value;
	assign option = queue_q[rd_ptr_q].option;
	assign last   = queue_q[rd_ptr_q].last;

	always_comb begin
		parse_d   = parse_q;
		echo_d    = echo_q;
		lsga_d    = lsga_q;
		rsga_d    = rsga_q;
		cmd0_v    = 1'b0;
		cmd1_v    = 1'b0;
		cmd0_code = '0;
		cmd0_opt  = '0;
		cmd1_code = '0;
		cmd1_opt  = '0;
		data_v    = 1'b0;
		data_byte = byte_in;
		ps_eff    = (parse_q == 3'd7) ? PS_NORMAL : parse_q;

		case (func)
			FUNC_RX_BYTE: begin
				parse_d = PS_NORMAL;
				case (ps_eff)
					PS_NORMAL: begin
						if (byte_in == IAC) begin
							parse_d = PS_IAC;
						end else begin
							data_v = (byte_in != CHNUL);
							if (byte_in == CHCRT) begin
								parse_d = PS_CR;
							end
						end
					end
					PS_CR: begin
						data_v = (byte_in != CHNUL) && (byte_in != CHLFD);
					end
					PS_IAC: begin
						case (byte_in)
							CMD_WILL: parse_d = PS_WILL;
							CMD_WONT: parse_d = PS_WONT;
							CMD_DO:   parse_d = PS_DO;
							CMD_DONT: parse_d = PS_DONT;
							IAC:      data_v  = 1'b1;
							default:  parse_d = PS_NORMAL;
						endcase
					end
					PS_WILL: begin
						if (byte_in == OPTION_SGA) begin
							cmd0_v    = (rsga_q != OS_WAITING);
							cmd0_code = CMD_DO;
							cmd0_opt  = OPTION_SGA;
							rsga_d    = OS_ENABLED;
						end else begin
							cmd0_v    = 1'b1;
							cmd0_code = CMD_DONT;
							cmd0_opt  = byte_in;
						end
					end
					PS_WONT: begin
						parse_d = PS_NORMAL;
					end
					PS_DO: begin
						if (byte_in == OPTION_SGA) begin
							cmd0_v    = (lsga_q != OS_WAITING);
							cmd0_code = CMD_WILL;
							cmd0_opt  = OPTION_SGA;
							lsga_d    = OS_ENABLED;
						end else if (byte_in == OPTION_ECHO) begin
							cmd0_opt = OPTION_ECHO;
							case (echo_q)
								OS_WAITING: echo_d = OS_DISABLED;
								OS_ENABLED: begin
									cmd0_v    = 1'b1;
									cmd0_code = CMD_WONT;
								end
								OS_DISABLED: begin
									cmd0_v    = 1'b1;
									cmd0_code = CMD_WILL;
								end
								default: cmd0_v = 1'b0;
							endcase
						end else begin
							cmd0_v    = 1'b1;
							cmd0_code = CMD_WONT;
							cmd0_opt  = byte_in;
						end
					end
					default: begin
						if (byte_in == OPTION_ECHO) begin
							echo_d = OS_ENABLED;
						end
					end
				endcase
			end
			FUNC_ECHO: begin
				cmd0_opt = OPTION_ECHO;
				if (echo_q != OS_WAITING) begin
					if (echo_on) begin
						if (echo_q != OS_ENABLED) begin
							cmd0_v    = 1'b1;
							cmd0_code = CMD_WONT;
							echo_d    = OS_WAITING;
						end
					end else begin
						if (echo_q != OS_DISABLED) begin
							cmd0_v    = 1'b1;
							cmd0_code = CMD_WILL;
							echo_d    = OS_WAITING;
						end
					end
				end
			end
			FUNC_SGA: begin
				cmd0_code = CMD_WILL;
				cmd0_opt  = OPTION_SGA;
				cmd1_code = CMD_DO;
				cmd1_opt  = OPTION_SGA;
				if (lsga_q != OS_ENABLED) begin
					cmd0_v = 1'b1;
					lsga_d = OS_WAITING;
				end
				if (rsga_q != OS_ENABLED) begin
					cmd1_v = 1'b1;
					rsga_d = OS_WAITING;
				end
			end
			default: begin
				parse_d = parse_q;
			end
		endcase
	end

	// Pack the replies into the first free result slots.
	always_comb begin
		res0  = '0;
		res1  = '0;
		push0 = 1'b0;
		push1 = 1'b0;
		if (data_v) begin
			push0       = 1'b1;
			res0.kind   = KIND_DATA;
			res0.value  = data_byte;
			res0.option = '0;
			res0.last   = 1'b1;
		end else if (cmd0_v) begin
			push0       = 1'b1;
			res0.kind   = KIND_CMD;
			res0.value  = cmd0_code;
			res0.option = cmd0_opt;
			res0.last   = !cmd1_v;
			if (cmd1_v) begin
				push1       = 1'b1;
				res1.kind   = KIND_CMD;
				res1.value  = cmd1_code;
				res1.option = cmd1_opt;
				res1.last   = 1'b1;
			end
		end else if (cmd1_v) begin
			push0       = 1'b1;
			res0.kind   = KIND_CMD;
			res0.value  = cmd1_code;
			res0.option = cmd1_opt;
			res0.last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PS_NORMAL;
			echo_q  <= OS_ENABLED;
			lsga_q  <= OS_DISABLED;
			rsga_q  <= OS_DISABLED;
		end else if (in_fire) begin
			parse_q <= parse_d;
			echo_q  <= echo_d;
			lsga_q  <= lsga_d;
			rsga_q  <= rsga_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(in_fire & push0) + PTR_W'(in_fire & push1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(out_fire);
			count_q  <= count_q + CNT_W'(in_fire & push0) + CNT_W'(in_fire & push1)
				- CNT_W'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_fire && push1) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

endmodule

FILE: sim/telnet_receive_negotiator_tb.sv
`timescale 1ns / 100ps

module telnet_receive_negotiator_tb;
	import tnrxneg_pkg::*;

	localparam func_t FUNC_UNUSED = 2'd3;
	localparam byte_t CMD_NOP = 8'd241;

	localparam logic [1:0] SINK_OPEN     = 2'd0;
	localparam logic [1:0] SINK_RANDOM   = 2'd1;
	localparam logic [1:0] SINK_PERIODIC = 2'd2;
	localparam logic [1:0] SINK_LONG     = 2'd3;

	localparam int RANDOM_REQUESTS = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 50;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	func_t func = FUNC_RX_BYTE;
	byte_t byte_in = 8'd0;
	logic  echo_on = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	logic  kind;
	byte_t value;
	byte_t option;
	logic  last;

	// Mirror of the line state, updated as each request is accepted.
	parse_state_t rx_parse;
	opt_state_t   echo_mode;
	opt_state_t   local_sga;
	opt_state_t   remote_sga;

	result_t expected_q[$];
	result_t new_results[$];

	int unsigned burst_left = 0;
	int unsigned requests_sent = 0;
	int unsigned requests_ignored = 0;
	int unsigned results_checked = 0;
	int unsigned data_results = 0;
	int unsigned cmd_results = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	logic [1:0]  sink_mode = SINK_OPEN;
	int unsigned sink_mode_left = 0;
	int unsigned sink_phase = 0;

	telnet_receive_negotiator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.byte_in   (byte_in),
		.echo_on   (echo_on),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.option    (option),
		.last      (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void add_result(logic k, byte_t v, byte_t o);
		result_t r;
		r.kind = k;
		r.value = v;
		r.option = o;
		r.last = 1'b0;
		new_results.push_back(r);
	endfunction

	// Works out the replies and host bytes that one request causes.
	function automatic void predict_line(func_t f, byte_t b, logic e);
		result_t r;
		new_results = {};
		case (f)
			FUNC_RX_BYTE: begin
				case (rx_parse)
					PS_CR: begin
						if (b != CHNUL && b != CHLFD)
							add_result(KIND_DATA, b, 8'd0);
						rx_parse = PS_NORMAL;
					end
					PS_IAC: begin
						if (b == CMD_WILL)
							rx_parse = PS_WILL;
						else if (b == CMD_WONT)
							rx_parse = PS_WONT;
						else if (b == CMD_DO)
							rx_parse = PS_DO;
						else if (b == CMD_DONT)
							rx_parse = PS_DONT;
						else begin
							if (b == IAC)
								add_result(KIND_DATA, IAC, 8'd0);
							rx_parse = PS_NORMAL;
						end
					end
					PS_WILL: begin
						if (b == OPTION_SGA) begin
							if (remote_sga != OS_WAITING)
								add_result(KIND_CMD, CMD_DO, OPTION_SGA);
							remote_sga = OS_ENABLED;
						end else begin
							add_result(KIND_CMD, CMD_DONT, b);
						end
						rx_parse = PS_NORMAL;
					end
					PS_WONT: begin
						rx_parse = PS_NORMAL;
					end
					PS_DO: begin
						if (b == OPTION_SGA) begin
							if (local_sga != OS_WAITING)
								add_result(KIND_CMD, CMD_WILL, OPTION_SGA);
							local_sga = OS_ENABLED;
						end else if (b == OPTION_ECHO) begin
							if (echo_mode == OS_WAITING)
								echo_mode = OS_DISABLED;
							else if (echo_mode == OS_ENABLED)
								add_result(KIND_CMD, CMD_WONT, OPTION_ECHO);
							else if (echo_mode == OS_DISABLED)
								add_result(KIND_CMD, CMD_WILL, OPTION_ECHO);
						end else begin
							add_result(KIND_CMD, CMD_WONT, b);
						end
						rx_parse = PS_NORMAL;
					end
					PS_DONT: begin
						if (b == OPTION_ECHO)
							echo_mode = OS_ENABLED;
						rx_parse = PS_NORMAL;
					end
					default: begin
						if (b == IAC) begin
							rx_parse = PS_IAC;
						end else begin
							if (b != CHNUL)
								add_result(KIND_DATA, b, 8'd0);
							rx_parse = (b == CHCRT) ? PS_CR : PS_NORMAL;
						end
					end
				endcase
			end
			FUNC_ECHO: begin
				if (echo_mode != OS_WAITING) begin
					if (e && echo_mode != OS_ENABLED) begin
						add_result(KIND_CMD, CMD_WONT, OPTION_ECHO);
						echo_mode = OS_WAITING;
					end else if (!e && echo_mode != OS_DISABLED) begin
						add_result(KIND_CMD, CMD_WILL, OPTION_ECHO);
						echo_mode = OS_WAITING;
					end
				end
			end
			FUNC_SGA: begin
				if (local_sga != OS_ENABLED) begin
					add_result(KIND_CMD, CMD_WILL, OPTION_SGA);
					local_sga = OS_WAITING;
				end
				if (remote_sga != OS_ENABLED) begin
					add_result(KIND_CMD, CMD_DO, OPTION_SGA);
					remote_sga = OS_WAITING;
				end
			end
			default: ;
		endcase
		if (new_results.size() > 0) begin
			r = new_results[new_results.size() - 1];
			r.last = 1'b1;
			new_results[new_results.size() - 1] = r;
		end
		foreach (new_results[i])
			expected_q.push_back(new_results[i]);
	endfunction

	// Drives one request and returns in the time step of the edge that accepts it.
	task automatic send_request(func_t f, byte_t b, logic e);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		byte_in <= b;
		echo_on <= e;
		do
			@(posedge clk);
		while (!in_ready);
		predict_line(f, b, e);
		if (f == FUNC_UNUSED)
			requests_ignored++;
		else
			requests_sent++;
	endtask

	// Received byte; echo_on carries junk since the block ignores it here.
	task automatic send_byte(byte_t b);
		send_request(FUNC_RX_BYTE, b, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_command(byte_t cmd, byte_t opt);
		send_byte(IAC);
		send_byte(cmd);
		send_byte(opt);
	endtask

	// The receiver alternates between open, random, periodic and long stall phases.
	always @(posedge clk) begin
		if (sink_mode_left == 0) begin
			sink_mode <= 2'($urandom_range(0, 3));
			sink_mode_left <= $urandom_range(40, 200);
		end else begin
			sink_mode_left <= sink_mode_left - 1;
		end
		sink_phase <= sink_phase + 1;
		case (sink_mode)
			SINK_OPEN:     out_ready <= 1'b1;
			SINK_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
			SINK_PERIODIC: out_ready <= (sink_phase % 7) > 2;
			default:       out_ready <= ($urandom_range(0, 9) == 0) ? ~out_ready : out_ready;
		endcase
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: result with nothing expected, got kind %0d value %0d option %0d last %0d",
						$time, kind, value, option, last);
				error_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("kind", want.kind, kind);
				check_field("value", want.value, value);
				check_field("option", want.option, option);
				check_field("last", want.last, last);
				results_checked++;
				if (want.kind == KIND_DATA)
					data_results++;
				else
					cmd_results++;
			end
		end
	end

	task automatic test_data_bytes();
		send_byte(CHNUL);
		send_byte(8'hFE);
		// CR LF and CR NUL collapse to the CR alone.
		send_byte(CHCRT);
		send_byte(CHLFD);
		send_byte(CHCRT);
		send_byte(CHNUL);
		// A second CR passes, and an IAC after a CR passes as data.
		send_byte(CHCRT);
		send_byte(CHCRT);
		send_byte(CHCRT);
		send_byte(IAC);
		send_byte(IAC);
		send_byte(IAC);
		send_byte(IAC);
		send_byte(CMD_NOP);
	endtask

	task automatic test_peer_negotiation();
		send_command(CMD_DO, OPTION_ECHO);
		send_command(CMD_WILL, 8'd0);
		send_command(CMD_DO, 8'hFF);
		send_command(CMD_WONT, OPTION_ECHO);
		send_command(CMD_DONT, OPTION_SGA);
	endtask

	task automatic test_local_requests();
		send_request(FUNC_ECHO, 8'h00, 1'b0);
		// The peer's answer to our own offer gets no further reply.
		send_command(CMD_DO, OPTION_ECHO);
		send_request(FUNC_ECHO, 8'hFF, 1'b1);
		send_command(CMD_DONT, OPTION_ECHO);
		send_request(FUNC_SGA, 8'hA5, 1'b1);
		send_request(FUNC_UNUSED, 8'h5A, 1'b1);
	endtask

	task automatic test_random_traffic();
		int unsigned start_count;
		int unsigned pick;
		byte_t opt;
		start_count = requests_sent;
		while (requests_sent - start_count < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_byte(byte_t'($urandom_range(0, 255)));
			end else if (pick < 60) begin
				case ($urandom_range(0, 4))
					0, 1:    opt = OPTION_ECHO;
					2, 3:    opt = OPTION_SGA;
					default: opt = byte_t'($urandom_range(0, 255));
				endcase
				send_command(byte_t'(CMD_WILL + $urandom_range(0, 3)), opt);
			end else if (pick < 70) begin
				send_byte(CHCRT);
				case ($urandom_range(0, 4))
					0:       send_byte(CHLFD);
					1:       send_byte(CHNUL);
					2:       send_byte(CHCRT);
					3:       send_byte(IAC);
					default: send_byte(byte_t'($urandom_range(0, 255)));
				endcase
			end else if (pick < 80) begin
				send_byte(IAC);
				send_byte(($urandom_range(0, 2) == 0) ? IAC : byte_t'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				send_request(FUNC_ECHO, byte_t'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (pick < 97) begin
				send_request(FUNC_SGA, byte_t'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				send_request(FUNC_UNUSED, byte_t'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		rx_parse = PS_NORMAL;
		echo_mode = OS_ENABLED;
		local_sga = OS_DISABLED;
		remote_sga = OS_DISABLED;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_data_bytes();
		test_peer_negotiation();
		test_local_requests();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d requests and %0d unused-function requests; checked %0d results.",
			requests_sent, requests_ignored, results_checked);
		$display("Results were %0d host bytes and %0d peer commands; %0d errors.",
			data_results, cmd_results, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
design/tnrxneg_pkg.sv
design/telnet_receive_negotiator.sv
sim/telnet_receive_negotiator_tb.sv
